// ----- src/dos_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dos_pkg
// Shared widths, codes, microprogram and fixed-point helpers for the decay
// equation stepper.
// ----------------------------------------------------------------------------
package dos_pkg;

    // number formats
    localparam int FRAC_BITS = 24;
    localparam int Q_W       = 32;           // stored values, Q8.24
    localparam int H_W       = Q_W + 1;      // step or time difference, exact
    localparam int P_W       = H_W + Q_W;    // full product
    localparam int S_W       = Q_W + 4;      // k1 + 2*k2 + 2*k3 + k4, exact
    localparam int STEP_W    = 31;           // step_size register
    localparam int CFG_IDX_W = 3;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [P_W:0]   RND_HALF = (P_W+1)'(1) <<< (FRAC_BITS - 1);

    // divide by three, one byte digit per cycle
    localparam int DIGIT_W    = 8;
    localparam int DIV_STEPS  = 5;
    localparam int DVD_W      = DIGIT_W * DIV_STEPS;
    localparam int CUR_W      = DIGIT_W + 2;
    localparam int DIV3_MUL   = 683;         // 2^11 / 3, exact below 768
    localparam int DIV3_SHIFT = 11;
    localparam int DCNT_W     = 3;

    // method codes
    localparam logic [1:0] METHOD_EULER = 2'd0;
    localparam logic [1:0] METHOD_RK2   = 2'd1;
    localparam logic [1:0] METHOD_RK4   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd5;

    // configuration reset values
    localparam logic [1:0]            RST_METHOD = METHOD_RK4;
    localparam logic [STEP_W-1:0]     RST_STEP   = 31'd1677722;
    localparam logic signed [Q_W-1:0] RST_START  = 32'sd0;
    localparam logic signed [Q_W-1:0] RST_VALUE  = 32'sd16777216;
    localparam logic signed [Q_W-1:0] RST_LOWER  = 32'sd0;
    localparam logic signed [Q_W-1:0] RST_UPPER  = 32'sd50331648;

    // micro-operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_INIT  = 3'd1;  // k = f(x), s = k
    localparam logic [2:0] OP_MUL   = 3'd2;  // p = h or h/2 times k
    localparam logic [2:0] OP_STAGE = 3'd3;  // k = f(x + p), s += k or 2k
    localparam logic [2:0] OP_FINAL = 3'd4;  // x = x + p
    localparam logic [2:0] OP_DPREP = 3'd5;  // load (s + 3) / 2 for divide by 3
    localparam logic [2:0] OP_DSTEP = 3'd6;  // one quotient digit
    localparam logic [2:0] OP_DFIN  = 3'd7;  // k = signed quotient

    // microprogram entry points
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] ENTRY_EULER = 5'd0;
    localparam logic [UPC_W-1:0] ENTRY_RK2   = 5'd3;
    localparam logic [UPC_W-1:0] ENTRY_RK4   = 5'd8;
    localparam logic [UPC_W-1:0] DLOOP_ADDR  = 5'd16;

    typedef struct packed {
        logic [2:0]       op;
        logic             half;   // multiply by h/2
        logic             dbl;    // add 2k to the running sum
        logic             loop;   // jump to tgt while divide digits remain
        logic             fin;    // last word of the routine
        logic [UPC_W-1:0] tgt;
    } uop_t;

    typedef struct packed {
        logic busy;
        logic done;
    } seq_stat_t;

    typedef struct packed {
        logic                   en;
        logic                   load_x;
        logic signed [Q_W-1:0]  x;
        logic signed [H_W-1:0]  h;
    } dp_load_t;

    function automatic uop_t uw(input logic [2:0] op, input logic half, input logic dbl,
                                input logic loop, input logic fin);
        uop_t w;
        w.op   = op;
        w.half = half;
        w.dbl  = dbl;
        w.loop = loop;
        w.fin  = fin;
        w.tgt  = DLOOP_ADDR;
        return w;
    endfunction

    // control store
    function automatic uop_t ucode_rom(input logic [UPC_W-1:0] addr);
        uop_t w;
        case (addr)
            // euler, also the start-point carry
            5'd0:    w = uw(OP_INIT,  1'b0, 1'b0, 1'b0, 1'b0);
            5'd1:    w = uw(OP_MUL,   1'b0, 1'b0, 1'b0, 1'b0);
            5'd2:    w = uw(OP_FINAL, 1'b0, 1'b0, 1'b0, 1'b1);
            // midpoint rk2
            5'd3:    w = uw(OP_INIT,  1'b0, 1'b0, 1'b0, 1'b0);
            5'd4:    w = uw(OP_MUL,   1'b1, 1'b0, 1'b0, 1'b0);
            5'd5:    w = uw(OP_STAGE, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd6:    w = uw(OP_MUL,   1'b0, 1'b0, 1'b0, 1'b0);
            5'd7:    w = uw(OP_FINAL, 1'b0, 1'b0, 1'b0, 1'b1);
            // classic rk4
            5'd8:    w = uw(OP_INIT,  1'b0, 1'b0, 1'b0, 1'b0);
            5'd9:    w = uw(OP_MUL,   1'b1, 1'b0, 1'b0, 1'b0);
            5'd10:   w = uw(OP_STAGE, 1'b0, 1'b1, 1'b0, 1'b0);
            5'd11:   w = uw(OP_MUL,   1'b1, 1'b0, 1'b0, 1'b0);
            5'd12:   w = uw(OP_STAGE, 1'b0, 1'b1, 1'b0, 1'b0);
            5'd13:   w = uw(OP_MUL,   1'b0, 1'b0, 1'b0, 1'b0);
            5'd14:   w = uw(OP_STAGE, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd15:   w = uw(OP_DPREP, 1'b0, 1'b0, 1'b0, 1'b0);
            5'd16:   w = uw(OP_DSTEP, 1'b0, 1'b0, 1'b1, 1'b0);
            5'd17:   w = uw(OP_DFIN,  1'b0, 1'b0, 1'b0, 1'b0);
            5'd18:   w = uw(OP_MUL,   1'b0, 1'b0, 1'b0, 1'b0);
            5'd19:   w = uw(OP_FINAL, 1'b0, 1'b0, 1'b0, 1'b1);
            default: w = uw(OP_NOP,   1'b0, 1'b0, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

    // clamp a wide signed value to the stored range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [P_W:0] v);
        logic signed [P_W:0] lim_hi;
        logic signed [P_W:0] lim_lo;
        lim_hi = (P_W+1)'(Q_MAX);
        lim_lo = (P_W+1)'(Q_MIN);
        if (v > lim_hi) return Q_MAX;
        if (v < lim_lo) return Q_MIN;
        return v[Q_W-1:0];
    endfunction

    // right-hand side f(x) = -x, saturated
    function automatic logic signed [Q_W-1:0] neg_sat(input logic signed [Q_W-1:0] v);
        return (v == Q_MIN) ? Q_MAX : -v;
    endfunction

endpackage
`default_nettype wire

// ----- src/dos_useq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dos_useq
// Microprogram sequencer: step counter over the control store, with a
// conditional jump used by the divide loop.
// ----------------------------------------------------------------------------
module dos_useq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [dos_pkg::UPC_W-1:0]   entry,
    input  wire logic                        div_zero,
    output dos_pkg::uop_t                    ctl,
    output dos_pkg::seq_stat_t               stat
);

    logic [dos_pkg::UPC_W-1:0] upc_reg;
    logic [dos_pkg::UPC_W-1:0] upc_next;
    logic                      busy_reg;
    logic                      busy_next;
    dos_pkg::uop_t             word;

    // fetch
    assign word = dos_pkg::ucode_rom(upc_reg);

    // next step
    always_comb
    begin
        upc_next  = upc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            upc_next  = entry;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (word.fin)
                busy_next = 1'b0;
            else if (word.loop && !div_zero)
                upc_next = word.tgt;
            else
                upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            busy_reg <= busy_next;
        end
    end

    // issue the word only while a routine runs
    always_comb
    begin
        ctl = word;
        if (!busy_reg)
        begin
            ctl.op   = dos_pkg::OP_NOP;
            ctl.loop = 1'b0;
            ctl.fin  = 1'b0;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && word.fin;

endmodule
`default_nettype wire

// ----- src/dos_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dos_dpath
// Datapath under microcode control: solution value, shared multiplier with
// rounding and saturation, stage sum and a byte-serial divide by three.
// ----------------------------------------------------------------------------
module dos_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dos_pkg::uop_t                 ctl,
    input  wire dos_pkg::dp_load_t             ld,
    output logic signed [dos_pkg::Q_W-1:0]     x_value,
    output logic                               div_zero
);

    logic signed [dos_pkg::Q_W-1:0]   x_reg;
    logic signed [dos_pkg::H_W-1:0]   h_reg;
    logic signed [dos_pkg::Q_W-1:0]   k_reg;
    logic signed [dos_pkg::S_W-1:0]   s_reg;
    logic signed [dos_pkg::P_W-1:0]   p_reg;
    logic [dos_pkg::DVD_W-1:0]        dvd_reg;
    logic [1:0]                       rem_reg;
    logic                             neg_reg;
    logic [dos_pkg::DCNT_W-1:0]       dcnt_reg;

    logic signed [dos_pkg::H_W-1:0]   a_op;
    logic signed [dos_pkg::P_W-1:0]   prod;
    logic signed [dos_pkg::P_W:0]     rnd_full;
    logic signed [dos_pkg::Q_W-1:0]   mres;
    logic signed [dos_pkg::P_W:0]     ysum;
    logic signed [dos_pkg::Q_W-1:0]   y;
    logic signed [dos_pkg::Q_W-1:0]   k_stage;
    logic signed [dos_pkg::Q_W-1:0]   k_first;
    logic signed [dos_pkg::S_W-1:0]   k_add;
    logic signed [dos_pkg::S_W-1:0]   m_sum;
    logic signed [dos_pkg::S_W-1:0]   w_half;
    logic signed [dos_pkg::S_W-1:0]   u_mag;
    logic [dos_pkg::CUR_W-1:0]        cur;
    logic [2*dos_pkg::CUR_W-1:0]      q_wide;
    logic [dos_pkg::DIGIT_W-1:0]      q_dig;
    logic [dos_pkg::CUR_W-1:0]        rem_full;
    logic signed [dos_pkg::DVD_W-1:0] quo;

    // multiplier, h or h/2 times k
    assign a_op = ctl.half ? (h_reg >>> 1) : h_reg;
    assign prod = a_op * k_reg;

    // round to nearest, ties up, then clamp
    assign rnd_full = ((dos_pkg::P_W+1)'(p_reg) + dos_pkg::RND_HALF) >>> dos_pkg::FRAC_BITS;
    assign mres     = dos_pkg::sat_q(rnd_full);

    // stage value and its slope
    assign ysum    = (dos_pkg::P_W+1)'(x_reg) + (dos_pkg::P_W+1)'(mres);
    assign y       = dos_pkg::sat_q(ysum);
    assign k_stage = dos_pkg::neg_sat(y);
    assign k_first = dos_pkg::neg_sat(x_reg);
    assign k_add   = ctl.dbl ? (dos_pkg::S_W'(k_stage) <<< 1) : dos_pkg::S_W'(k_stage);

    // (s + 3) / 6 as ((s + 3) >> 1) / 3 on a magnitude
    assign m_sum  = s_reg + dos_pkg::S_W'(3);
    assign w_half = m_sum >>> 1;
    assign u_mag  = w_half[dos_pkg::S_W-1] ? (dos_pkg::S_W'(2) - w_half) : w_half;

    // one quotient byte
    assign cur      = {rem_reg, dvd_reg[dos_pkg::DVD_W-1 -: dos_pkg::DIGIT_W]};
    assign q_wide   = ((2*dos_pkg::CUR_W)'(cur) * (2*dos_pkg::CUR_W)'(dos_pkg::DIV3_MUL))
                      >> dos_pkg::DIV3_SHIFT;
    assign q_dig    = q_wide[dos_pkg::DIGIT_W-1:0];
    assign rem_full = cur - dos_pkg::CUR_W'(q_dig) * dos_pkg::CUR_W'(3);
    assign quo      = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

    // control counter for the divide loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (ctl.op == dos_pkg::OP_DPREP)
            dcnt_reg <= dos_pkg::DCNT_W'(dos_pkg::DIV_STEPS - 1);
        else if (ctl.op == dos_pkg::OP_DSTEP && dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - 1'b1;
    end

    assign div_zero = (dcnt_reg == '0);

    // solution value and step, value reads as zero before the first restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            h_reg <= '0;
        end
        else if (ld.en)
        begin
            h_reg <= ld.h;
            if (ld.load_x)
                x_reg <= ld.x;
        end
        else if (ctl.op == dos_pkg::OP_FINAL)
            x_reg <= y;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            dos_pkg::OP_INIT:
            begin
                k_reg <= k_first;
                s_reg <= dos_pkg::S_W'(k_first);
            end
            dos_pkg::OP_MUL:
                p_reg <= prod;
            dos_pkg::OP_STAGE:
            begin
                k_reg <= k_stage;
                s_reg <= s_reg + k_add;
            end
            dos_pkg::OP_DPREP:
            begin
                dvd_reg <= dos_pkg::DVD_W'(u_mag);
                rem_reg <= 2'b00;
                neg_reg <= w_half[dos_pkg::S_W-1];
            end
            dos_pkg::OP_DSTEP:
            begin
                dvd_reg <= {dvd_reg[dos_pkg::DVD_W-dos_pkg::DIGIT_W-1:0], q_dig};
                rem_reg <= rem_full[1:0];
            end
            dos_pkg::OP_DFIN:
                k_reg <= quo[dos_pkg::Q_W-1:0];
            default:
            begin
            end
        endcase
    end

    assign x_value = x_reg;

endmodule
`default_nettype wire

// ----- src/decay_ode_stepper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decay_ode_stepper
// Fixed-step integrator for dx/dt = -x by Euler, midpoint RK2 or classic
// RK4 in saturating Q8.24, run by a microprogram over one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in       | in        | in_valid / in_stall | restart
//  out      | out       | out_valid/out_stall | t_value, x_value, advanced, last
//  cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item at a time. An item that runs no routine goes straight to the
//  emit state; otherwise the time to a result is set by the microprogram
//  length of Euler (also run by a restart that carries x forward), RK2 or
//  RK4, with RK4 also spending time in the byte-serial divide by three.
//  in_stall is high while an item is in work; a new item is taken while
//  the previous result still waits in the output register.
//  Reset clears control, state flags and loads the register defaults.
// ----------------------------------------------------------------------------
module decay_ode_stepper (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  restart,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [dos_pkg::Q_W-1:0]             t_value,
    output logic signed [dos_pkg::Q_W-1:0]             x_value,
    output logic                                       advanced,
    output logic                                       last,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [dos_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [dos_pkg::Q_W-1:0]               cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // configuration registers
    logic [1:0]                        method_reg;
    logic [dos_pkg::STEP_W-1:0]        step_reg;
    logic signed [dos_pkg::Q_W-1:0]    start_t_reg;
    logic signed [dos_pkg::Q_W-1:0]    start_x_reg;
    logic signed [dos_pkg::Q_W-1:0]    lower_reg;
    logic signed [dos_pkg::Q_W-1:0]    upper_reg;

    // integration state
    logic signed [dos_pkg::Q_W-1:0]    t_reg;
    logic                              running_reg;
    logic                              finished_reg;
    logic                              adv_reg;
    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;

    // output register
    logic                              out_valid_reg;
    logic signed [dos_pkg::Q_W-1:0]    out_t_reg;
    logic signed [dos_pkg::Q_W-1:0]    out_x_reg;
    logic                              out_adv_reg;
    logic                              out_last_reg;

    logic                              in_take;
    logic                              out_free;
    logic                              cfg_take;
    logic                              do_step;
    logic                              seq_start;
    logic [dos_pkg::UPC_W-1:0]         seq_entry;
    logic [dos_pkg::UPC_W-1:0]         method_entry;
    dos_pkg::uop_t                     ctl;
    dos_pkg::seq_stat_t                seq_stat;
    dos_pkg::dp_load_t                 ld;
    logic signed [dos_pkg::Q_W-1:0]    x_now;
    logic                              div_zero;

    // time arithmetic
    logic [dos_pkg::STEP_W-1:0]        h_eff;
    logic signed [dos_pkg::H_W-1:0]    t_ext;
    logic signed [dos_pkg::H_W-1:0]    h_ext;
    logic signed [dos_pkg::H_W-1:0]    up_ext;
    logic signed [dos_pkg::H_W-1:0]    tn_ext;
    logic                              overshoot;
    logic signed [dos_pkg::H_W-1:0]    h_step;
    logic signed [dos_pkg::Q_W-1:0]    tn;
    logic signed [dos_pkg::Q_W-1:0]    t0;
    logic signed [dos_pkg::H_W-1:0]    dt;
    logic                              carry;

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg  <= dos_pkg::RST_METHOD;
            step_reg    <= dos_pkg::RST_STEP;
            start_t_reg <= dos_pkg::RST_START;
            start_x_reg <= dos_pkg::RST_VALUE;
            lower_reg   <= dos_pkg::RST_LOWER;
            upper_reg   <= dos_pkg::RST_UPPER;
        end
        else if (cfg_take)
        begin
            case (cfg_index)
                dos_pkg::CFG_METHOD: method_reg  <= cfg_data[1:0];
                dos_pkg::CFG_STEP:   step_reg    <= cfg_data[dos_pkg::STEP_W-1:0];
                dos_pkg::CFG_START:  start_t_reg <= cfg_data;
                dos_pkg::CFG_VALUE:  start_x_reg <= cfg_data;
                dos_pkg::CFG_LOWER:  lower_reg   <= cfg_data;
                dos_pkg::CFG_UPPER:  upper_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // next time point, clipped to the upper bound
    assign h_eff     = (step_reg == '0) ? dos_pkg::STEP_W'(1) : step_reg;
    assign t_ext     = dos_pkg::H_W'(t_reg);
    assign h_ext     = $signed({2'b00, h_eff});
    assign up_ext    = dos_pkg::H_W'(upper_reg);
    assign tn_ext    = t_ext + h_ext;
    assign overshoot = (tn_ext > up_ext);
    assign h_step    = overshoot ? (up_ext - t_ext) : h_ext;
    assign tn        = overshoot ? upper_reg : tn_ext[dos_pkg::Q_W-1:0];

    // restart point and carry distance
    assign t0    = (start_t_reg > lower_reg) ? start_t_reg : lower_reg;
    assign dt    = dos_pkg::H_W'(t0) - dos_pkg::H_W'(start_t_reg);
    assign carry = (t0 > start_t_reg);

    // method routine, unused code runs rk4
    always_comb
    begin
        case (method_reg)
            dos_pkg::METHOD_EULER: method_entry = dos_pkg::ENTRY_EULER;
            dos_pkg::METHOD_RK2:   method_entry = dos_pkg::ENTRY_RK2;
            default:               method_entry = dos_pkg::ENTRY_RK4;
        endcase
    end

    // item decode
    assign do_step   = !restart && running_reg && !finished_reg;
    assign seq_start = in_take && (restart ? carry : do_step);
    assign seq_entry = restart ? dos_pkg::ENTRY_EULER : method_entry;

    always_comb
    begin
        ld.en     = in_take && (restart || do_step);
        ld.load_x = restart;
        ld.x      = start_x_reg;
        ld.h      = restart ? dt : h_step;
    end

    // integration state update at accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg        <= '0;
            running_reg  <= 1'b0;
            finished_reg <= 1'b0;
            adv_reg      <= 1'b0;
        end
        else if (in_take)
        begin
            adv_reg <= restart || do_step;
            if (restart)
            begin
                t_reg        <= t0;
                running_reg  <= 1'b1;
                finished_reg <= (t0 >= upper_reg);
            end
            else if (do_step)
            begin
                t_reg        <= tn;
                finished_reg <= (tn >= upper_reg);
            end
        end
    end

    // control state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_take)
                    state_next = seq_start ? ST_RUN : ST_EMIT;
            ST_RUN:
                if (seq_stat.done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_EMIT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            out_t_reg    <= t_reg;
            out_x_reg    <= x_now;
            out_adv_reg  <= adv_reg;
            out_last_reg <= running_reg && finished_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign t_value   = out_t_reg;
    assign x_value   = out_x_reg;
    assign advanced  = out_adv_reg;
    assign last      = out_last_reg;

    // sequencer and datapath
    dos_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (seq_start),
        .entry    (seq_entry),
        .div_zero (div_zero),
        .ctl      (ctl),
        .stat     (seq_stat)
    );

    dos_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .ld       (ld),
        .x_value  (x_now),
        .div_zero (div_zero)
    );

    // the microprogram runs exactly while the control state says so
    a_run_matches_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) == seq_stat.busy)
        else $error("sequencer activity out of step with control state");

    // a finished trajectory was always started
    a_finished_running: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> running_reg)
        else $error("finished flag set without a started trajectory");

    // a new result only comes from the emit state
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result presented outside the emit state");

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decay equation stepper. A short table of
// directed transactions and register writes is run first, then random settings
// and restart/step streams under several idle and stall mixes. Every result is
// compared field by field with a local fixed-point model or a typed-in point.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     HALF_PERIOD = 6;
    localparam int     RESET_CYCLES = 12;
    localparam int     TAIL_CYCLES = 24;              // longer than an rk4 step
    localparam longint TIMEOUT_NS = 64'd6_000_000;
    localparam int     REPORT_LIMIT = 10;
    localparam int     FRAC = 24;
    localparam longint ONE_Q = 64'sd1 <<< FRAC;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam longint RK4_DIVISOR = 64'sd6;          // weights 1, 2, 2, 1
    localparam logic [dos_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7; // no register behind it
    localparam int     N_DIRECTED = 30;
    localparam int     N_PHASES = 4;
    localparam int     SETTINGS_PER_PHASE = 5;

    typedef struct packed {
        logic signed [dos_pkg::Q_W-1:0] time_q;
        logic signed [dos_pkg::Q_W-1:0] value_q;
        logic                           adv_f;
        logic                           last_f;
    } point_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic                           restart_bit;
        logic [dos_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [dos_pkg::Q_W-1:0]        reg_data;
        logic                           typed;
        point_t                         want;
    } script_row_t;

    localparam point_t NO_POINT = '0;

    // clock and block inputs, all known from time zero
    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          restart = 1'b0;
    logic                          out_stall = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [dos_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dos_pkg::Q_W-1:0]       cfg_data = '0;

    logic                           in_stall;
    logic                           out_valid;
    logic signed [dos_pkg::Q_W-1:0] t_value;
    logic signed [dos_pkg::Q_W-1:0] x_value;
    logic                           advanced;
    logic                           last;
    logic                           cfg_ready;

    // model copy of the registers, reset values
    logic [1:0] reg_method = dos_pkg::METHOD_RK4;
    longint     reg_step = 64'sd1677722;
    longint     reg_start = 64'sd0;
    longint     reg_value = 64'sd16777216;
    longint     reg_lower = 64'sd0;
    longint     reg_upper = 64'sd50331648;

    // model copy of the solution state
    longint sol_time = 64'sd0;
    longint sol_value = 64'sd0;
    bit     sol_running = 1'b0;
    bit     sol_done = 1'b0;

    point_t      points_due[$];
    point_t      head_point;
    int          bad_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned out_stall_pct = 0;

    // directed transactions; expected points typed in only where obvious
    script_row_t directed_rows [N_DIRECTED] = '{
        // step before any restart, then the reset start point
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b0}},
        '{ROW_ITEM,  1'b1, dos_pkg::CFG_METHOD, 32'h0, 1'b1,
          '{32'h0, 32'h0100_0000, 1'b1, 1'b0}},
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b0, NO_POINT},
        // each method in turn, garbage in the unused data bits
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_METHOD, 32'hFFFF_FFFC, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b0, NO_POINT},
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_METHOD, 32'h0000_0001, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b0, NO_POINT},
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_METHOD, 32'h8000_0003, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b0, NO_POINT},
        // zero step acts as one lsb, then a huge step clipped to the end
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_STEP,   32'h8000_0000, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b0, NO_POINT},
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_STEP,   32'h7FFF_FFFF, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b0, NO_POINT},
        // most negative start value and time, carried forward to zero
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_VALUE,  32'h8000_0000, 1'b0, NO_POINT},
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_START,  32'h8000_0000, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b1, dos_pkg::CFG_METHOD, 32'h0, 1'b0, NO_POINT},
        // start past the end, then a step once finished
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_START,  32'h7FFF_FFFF, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b1, dos_pkg::CFG_METHOD, 32'h0, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1}},
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1}},
        // widest carry: from the most negative to the most positive time
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_VALUE,  32'h7FFF_FFFF, 1'b0, NO_POINT},
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_START,  32'h8000_0000, 1'b0, NO_POINT},
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_LOWER,  32'h7FFF_FFFF, 1'b0, NO_POINT},
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_UPPER,  32'h7FFF_FFFF, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b1, dos_pkg::CFG_METHOD, 32'h0, 1'b0, NO_POINT},
        // everything at the bottom of the time range
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_UPPER,  32'h8000_0000, 1'b0, NO_POINT},
        '{ROW_WRITE, 1'b0, dos_pkg::CFG_LOWER,  32'h8000_0000, 1'b0, NO_POINT},
        '{ROW_WRITE, 1'b0, CFG_SPARE,           32'hFFFF_FFFF, 1'b0, NO_POINT},
        '{ROW_ITEM,  1'b1, dos_pkg::CFG_METHOD, 32'h0, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1}},
        '{ROW_ITEM,  1'b0, dos_pkg::CFG_METHOD, 32'h0, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1}}
    };

    decay_ode_stepper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .t_value   (t_value),
        .x_value   (x_value),
        .advanced  (advanced),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // clamp to the 32-bit word
    function automatic longint sat_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // n / d rounded to nearest, ties toward +infinity
    function automatic longint round_div(input longint n, input longint d);
        longint m;
        longint q;
        m = n + d / 2;
        q = m / d;
        if ((m % d) != 0 && m < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return sat_word(round_div(a * b, ONE_Q));
    endfunction

    // right-hand side of dx/dt = -x
    function automatic longint decay_rate(input longint x);
        return sat_word(-x);
    endfunction

    // advance the solution for one accepted transaction and return its point
    function automatic point_t next_point(input logic rs);
        longint t_org;
        longint x_org;
        longint h;
        longint hh;
        longint t_next;
        longint x;
        longint k1;
        longint k2;
        longint k3;
        longint k4;
        point_t p;
        p = NO_POINT;
        if (rs)
        begin
            t_org = (reg_start > reg_lower) ? reg_start : reg_lower;
            x_org = reg_value;
            // one euler carry when the output interval opens after the start
            if (t_org > reg_start)
                x_org = sat_word(reg_value + fx_mul(t_org - reg_start,
                                                    decay_rate(reg_value)));
            sol_time = t_org;
            sol_value = x_org;
            sol_running = 1'b1;
            sol_done = (t_org >= reg_upper);
            p.adv_f = 1'b1;
        end
        else if (sol_running && !sol_done)
        begin
            h = (reg_step > 0) ? reg_step : 64'sd1;
            t_next = sol_time + h;
            // last step lands exactly on the upper time
            if (t_next > reg_upper)
            begin
                h = reg_upper - sol_time;
                t_next = reg_upper;
            end
            hh = h / 2;
            x = sol_value;
            k1 = decay_rate(x);
            if (reg_method == dos_pkg::METHOD_EULER)
                x = sat_word(x + fx_mul(h, k1));
            else
            begin
                k2 = decay_rate(sat_word(x + fx_mul(hh, k1)));
                if (reg_method == dos_pkg::METHOD_RK2)
                    x = sat_word(x + fx_mul(h, k2));
                else
                begin
                    // classic rk4, also for the unused method code
                    k3 = decay_rate(sat_word(x + fx_mul(hh, k2)));
                    k4 = decay_rate(sat_word(x + fx_mul(h, k3)));
                    x = sat_word(x + fx_mul(h, round_div(k1 + 2 * k2 + 2 * k3 + k4,
                                                         RK4_DIVISOR)));
                end
            end
            sol_value = x;
            sol_time = t_next;
            sol_done = (t_next >= reg_upper);
            p.adv_f = 1'b1;
        end
        p.time_q = sol_time[dos_pkg::Q_W-1:0];
        p.value_q = sol_value[dos_pkg::Q_W-1:0];
        p.last_f = sol_running && sol_done;
        return p;
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic offer_item(input logic rs, input logic typed, input point_t want);
        point_t p;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        restart <= rs;
        do
            @(posedge clk);
        while (in_stall);
        p = next_point(rs);
        points_due.insert(points_due.size(), typed ? want : p);
        @(negedge clk);
    endtask

    // register write; caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [dos_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dos_pkg::Q_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            dos_pkg::CFG_METHOD: reg_method = data[1:0];
            dos_pkg::CFG_STEP:   reg_step = longint'({1'b0, data[dos_pkg::STEP_W-1:0]});
            dos_pkg::CFG_START:  reg_start = longint'($signed(data));
            dos_pkg::CFG_VALUE:  reg_value = longint'($signed(data));
            dos_pkg::CFG_LOWER:  reg_lower = longint'($signed(data));
            dos_pkg::CFG_UPPER:  reg_upper = longint'($signed(data));
            default:    ;
        endcase
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (points_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [dos_pkg::Q_W-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // write all registers; most settings give runs of a few dozen steps
    task automatic load_random_setting(input bit at_limits);
        logic signed [dos_pkg::Q_W-1:0] t_begin;
        logic signed [dos_pkg::Q_W-1:0] t_low;
        logic signed [dos_pkg::Q_W-1:0] t_high;
        logic signed [dos_pkg::Q_W-1:0] t_org;
        logic [dos_pkg::Q_W-1:0]        x_start;
        logic [dos_pkg::Q_W-1:0]        span;
        logic [dos_pkg::Q_W-1:0]        stride;
        if (at_limits)
        begin
            t_begin = pick_limit();
            t_low = pick_limit();
            t_high = pick_limit();
            x_start = pick_limit();
            stride = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'h7FFF_FFFF;
        end
        else
        begin
            t_begin = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            t_low = t_begin + $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            t_org = (t_begin > t_low) ? t_begin : t_low;
            span = $urandom_range(1, 32'h0400_0000);
            // now and then the end lies at or before the start
            t_high = ($urandom_range(0, 9) == 0) ? t_org - $signed(span)
                                                 : t_org + $signed(span);
            stride = span / $urandom_range(1, 40);
            x_start = $urandom;
        end
        stride[dos_pkg::Q_W-1] = $urandom_range(0, 1);
        write_reg(dos_pkg::CFG_METHOD, $urandom);
        write_reg(dos_pkg::CFG_STEP, stride);
        write_reg(dos_pkg::CFG_START, t_begin);
        write_reg(dos_pkg::CFG_VALUE, x_start);
        write_reg(dos_pkg::CFG_LOWER, t_low);
        write_reg(dos_pkg::CFG_UPPER, t_high);
        cfg_valid <= 1'b0;
    endtask

    // receiver stall, redrawn every cycle
    always @(negedge clk)
        out_stall <= (out_stall_pct != 0) && ($urandom_range(0, 99) < out_stall_pct);

    // check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (points_due.size() == 0)
            begin
                bad_count++;
                if (bad_count <= REPORT_LIMIT)
                    $display("%0t unexpected result: t %h x %h adv %b last %b",
                             $realtime, t_value, x_value, advanced, last);
            end
            else
            begin
                head_point = points_due.pop_front();
                if (t_value !== head_point.time_q || x_value !== head_point.value_q ||
                    advanced !== head_point.adv_f || last !== head_point.last_f)
                begin
                    bad_count++;
                    if (bad_count <= REPORT_LIMIT)
                        $display("%0t mismatch exp/act: t %h/%h x %h/%h adv %b/%b last %b/%b",
                                 $realtime, head_point.time_q, t_value,
                                 head_point.value_q, x_value, head_point.adv_f, advanced,
                                 head_point.last_f, last);
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int unsigned phase_idle [N_PHASES];
        int unsigned phase_stall [N_PHASES];
        int unsigned n_items;
        logic        rs;

        phase_idle = '{0, 49, 0, 18};
        phase_stall = '{0, 0, 49, 18};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                settle_idle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                offer_item(directed_rows[r].restart_bit, directed_rows[r].typed,
                           directed_rows[r].want);
            end
        end

        // random settings under each idle mix, limits first
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            for (int s = 0; s < SETTINGS_PER_PHASE; s++)
            begin
                settle_idle();
                send_idle_pct = phase_idle[ph];
                out_stall_pct = phase_stall[ph];
                load_random_setting(s == 0);
                n_items = $urandom_range(60, 105);
                for (int i = 0; i < n_items; i++)
                begin
                    // mostly restart then step to the end, some stray restarts
                    if (i == 0)
                        rs = ($urandom_range(0, 9) < 7);
                    else if (sol_done)
                        rs = ($urandom_range(0, 1) == 0);
                    else
                        rs = ($urandom_range(0, 99) < 6);
                    offer_item(rs, 1'b0, NO_POINT);
                end
            end
        end

        settle_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (bad_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
